// File: sv/tla_pkg.sv
// shared types and constants for the two-line assembly schedule datapath
`default_nettype none

package tla_pkg;

    // widths fixed by the port definition
    localparam int FIELD_W = 16;
    localparam int CFG_W   = 16;
    localparam int OUT_W   = 32;
    localparam int IDX_W   = 2;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_ENTRY_ZERO = 2'd0;
    localparam logic [IDX_W-1:0] REG_ENTRY_ONE  = 2'd1;
    localparam logic [IDX_W-1:0] REG_EXIT_ZERO  = 2'd2;
    localparam logic [IDX_W-1:0] REG_EXIT_ONE   = 2'd3;

    // configuration register file contents
    typedef struct packed {
        logic [CFG_W-1:0] entry_cost_zero;
        logic [CFG_W-1:0] entry_cost_one;
        logic [CFG_W-1:0] exit_cost_zero;
        logic [CFG_W-1:0] exit_cost_one;
    } cfg_regs_t;

    // one result item as it sits in the output queue
    typedef struct packed {
        logic [OUT_W-1:0] best_cost_zero;
        logic [OUT_W-1:0] best_cost_one;
        logic             pred_for_zero;
        logic             pred_for_one;
        logic [OUT_W-1:0] total_cost;
        logic             exit_line;
        logic             final_res;
    } res_t;

endpackage

`default_nettype wire

// File: sv/tla_fifo.sv
// small synchronous queue with full and empty flags
`default_nettype none

module tla_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    // depth must be a power of two so the pointers wrap on their own; the module does not check it
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wptr_reg;
    logic [AW-1:0]    wptr_next;
    logic [AW-1:0]    rptr_reg;
    logic [AW-1:0]    rptr_next;
    logic [AW:0]      count_reg;
    logic [AW:0]      count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wptr_next  = do_wr ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = do_rd ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // storage write
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// File: sv/tla_front.sv
// front end: marks sequence start and pre-adds station times to entry and transfer costs
`default_nettype none

module tla_front #(
    parameter int COST_BITS = 16,
    parameter int MID_W     = 70
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire tla_pkg::cfg_regs_t            cfg,
    input  wire logic                          item_xfer,
    input  wire logic [tla_pkg::FIELD_W-1:0]   work_time_zero,
    input  wire logic [tla_pkg::FIELD_W-1:0]   work_time_one,
    input  wire logic [tla_pkg::FIELD_W-1:0]   move_cost_from_zero,
    input  wire logic [tla_pkg::FIELD_W-1:0]   move_cost_from_one,
    input  wire logic                          last_station,
    output logic [MID_W-1:0]                   mid_data
);

    import tla_pkg::*;

    // costs are taken as their low CW bits, the smaller of COST_BITS and FIELD_W
    localparam int CW = (COST_BITS < FIELD_W) ? COST_BITS : FIELD_W;

    logic          first_reg;
    logic          first_next;
    logic [CW-1:0] w0;
    logic [CW-1:0] w1;
    logic [CW-1:0] m0;
    logic [CW-1:0] m1;
    logic [CW-1:0] en0;
    logic [CW-1:0] en1;
    logic [CW:0]   stay_add0;
    logic [CW:0]   stay_add1;
    logic [CW:0]   move_add0;
    logic [CW:0]   move_add1;

    assign w0  = work_time_zero[CW-1:0];
    assign w1  = work_time_one[CW-1:0];
    assign m0  = move_cost_from_zero[CW-1:0];
    assign m1  = move_cost_from_one[CW-1:0];
    assign en0 = cfg.entry_cost_zero[CW-1:0];
    assign en1 = cfg.entry_cost_one[CW-1:0];

    // first station adds entry cost, later stations add nothing extra to the stay path
    always_comb
    begin
        if (first_reg)
        begin
            stay_add0 = {1'b0, w0} + {1'b0, en0};
            stay_add1 = {1'b0, w1} + {1'b0, en1};
        end
        else
        begin
            stay_add0 = {1'b0, w0};
            stay_add1 = {1'b0, w1};
        end
        move_add0 = {1'b0, m1} + {1'b0, w0};
        move_add1 = {1'b0, m0} + {1'b0, w1};
    end

    assign mid_data = {first_reg, last_station, stay_add0, move_add0, stay_add1, move_add1};

    // next item starts a new sequence after a last station
    assign first_next = item_xfer ? last_station : first_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b1;
        end
        else
        begin
            first_reg <= first_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/tla_back.sv
// back end: add-compare-select per line, running costs and exit selection
`default_nettype none

module tla_back #(
    parameter int COST_BITS = 16,
    parameter int SUM_BITS  = 32,
    parameter int MID_W     = 70
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tla_pkg::cfg_regs_t cfg,
    input  wire logic [MID_W-1:0]   mid_data,
    input  wire logic               mid_empty,
    output logic                    mid_pop,
    input  wire logic               res_full,
    output logic                    res_push,
    output tla_pkg::res_t           res_data
);

    import tla_pkg::*;

    localparam int CW    = (COST_BITS < FIELD_W) ? COST_BITS : FIELD_W;
    localparam int ADD_W = ((SUM_BITS > CW + 1) ? SUM_BITS : CW + 1) + 1;
    localparam int RW    = (SUM_BITS > OUT_W) ? SUM_BITS : OUT_W;
    localparam logic [ADD_W-1:0] SUM_MAX = ADD_W'({SUM_BITS{1'b1}});
    localparam logic [RW-1:0]    OUT_MAX = RW'({OUT_W{1'b1}});

    // saturating add of a running cost and a cost term
    function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] a,
                                                    input logic [CW:0] b);
        logic [ADD_W-1:0] s;
        s = ADD_W'(a) + ADD_W'(b);
        if (s > SUM_MAX)
        begin
            s = SUM_MAX;
        end
        return s[SUM_BITS-1:0];
    endfunction

    // clamp to the reported width
    function automatic logic [OUT_W-1:0] report(input logic [SUM_BITS-1:0] v);
        logic [RW-1:0] vx;
        vx = RW'(v);
        if (vx > OUT_MAX)
        begin
            vx = OUT_MAX;
        end
        return vx[OUT_W-1:0];
    endfunction

    logic [SUM_BITS-1:0] run0_reg;
    logic [SUM_BITS-1:0] run0_next;
    logic [SUM_BITS-1:0] run1_reg;
    logic [SUM_BITS-1:0] run1_next;
    logic                is_first;
    logic                is_last;
    logic [CW:0]         stay_add0;
    logic [CW:0]         move_add0;
    logic [CW:0]         stay_add1;
    logic [CW:0]         move_add1;
    logic [SUM_BITS-1:0] base0;
    logic [SUM_BITS-1:0] base1;
    logic [SUM_BITS-1:0] stay0;
    logic [SUM_BITS-1:0] move0;
    logic [SUM_BITS-1:0] stay1;
    logic [SUM_BITS-1:0] move1;
    logic [SUM_BITS-1:0] c0;
    logic [SUM_BITS-1:0] c1;
    logic                p0;
    logic                p1;
    logic [SUM_BITS-1:0] e0;
    logic [SUM_BITS-1:0] e1;
    logic [SUM_BITS-1:0] total;
    logic                xline;
    logic                step;

    assign {is_first, is_last, stay_add0, move_add0, stay_add1, move_add1} = mid_data;

    // one station per cycle when a station waits and the result queue has room
    assign step     = !mid_empty && !res_full;
    assign mid_pop  = step;
    assign res_push = step;

    // add-compare-select, staying wins ties
    always_comb
    begin
        base0 = is_first ? '0 : run0_reg;
        base1 = is_first ? '0 : run1_reg;
        stay0 = sat_add(base0, stay_add0);
        stay1 = sat_add(base1, stay_add1);
        move0 = sat_add(run1_reg, move_add0);
        move1 = sat_add(run0_reg, move_add1);
        if (is_first || stay0 <= move0)
        begin
            c0 = stay0;
            p0 = 1'b0;
        end
        else
        begin
            c0 = move0;
            p0 = 1'b1;
        end
        if (is_first || stay1 <= move1)
        begin
            c1 = stay1;
            p1 = 1'b1;
        end
        else
        begin
            c1 = move1;
            p1 = 1'b0;
        end
    end

    // exit costs on the last station, line zero wins ties
    always_comb
    begin
        e0    = sat_add(c0, {1'b0, cfg.exit_cost_zero[CW-1:0]});
        e1    = sat_add(c1, {1'b0, cfg.exit_cost_one[CW-1:0]});
        total = '0;
        xline = 1'b0;
        if (is_last)
        begin
            if (e0 <= e1)
            begin
                total = e0;
            end
            else
            begin
                total = e1;
                xline = 1'b1;
            end
        end
    end

    always_comb
    begin
        res_data.best_cost_zero = report(c0);
        res_data.best_cost_one  = report(c1);
        res_data.pred_for_zero  = p0;
        res_data.pred_for_one   = p1;
        res_data.total_cost     = report(total);
        res_data.exit_line      = xline;
        res_data.final_res      = is_last;
    end

    // running costs
    assign run0_next = step ? c0 : run0_reg;
    assign run1_next = step ? c1 : run1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run0_reg <= '0;
            run1_reg <= '0;
        end
        else
        begin
            run0_reg <= run0_next;
            run1_reg <= run1_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/two_line_assembly_schedule_dp.sv
// top level of the two-line assembly schedule datapath
//
//  channel   handshake         payload
//  -------   ---------------   -------------------------------------------------
//  station   push / full       work_time_*, move_cost_from_*, last_station
//  result    pop / empty       best_cost_*, pred_for_*, total_cost, exit_line,
//                              final_res
//  config    cfg_wr_en         cfg_index, cfg_data
//
//  One station per clock is sustained while the result side does not stall;
//  a result shows on the ports once the station queue has held its station
//  and the back end has written the result queue. The back end computes
//  both lines' add-compare-select and the exit choice combinationally. full
//  rises when the two-entry station queue holds two stations, which happens
//  only while the result side stalls. Reset empties both queues, clears the
//  config registers and makes the next station a sequence start.
`default_nettype none

module two_line_assembly_schedule_dp #(
    parameter int COST_BITS = 16,
    parameter int SUM_BITS  = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [tla_pkg::FIELD_W-1:0]   work_time_zero,
    input  wire logic [tla_pkg::FIELD_W-1:0]   work_time_one,
    input  wire logic [tla_pkg::FIELD_W-1:0]   move_cost_from_zero,
    input  wire logic [tla_pkg::FIELD_W-1:0]   move_cost_from_one,
    input  wire logic                          last_station,
    input  wire logic                          pop,
    output logic                               empty,
    output logic [tla_pkg::OUT_W-1:0]          best_cost_zero,
    output logic [tla_pkg::OUT_W-1:0]          best_cost_one,
    output logic                               pred_for_zero,
    output logic                               pred_for_one,
    output logic [tla_pkg::OUT_W-1:0]          total_cost,
    output logic                               exit_line,
    output logic                               final_res,
    input  wire logic                          cfg_wr_en,
    input  wire logic [tla_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [tla_pkg::CFG_W-1:0]     cfg_data
);

    import tla_pkg::*;

    localparam int CW    = (COST_BITS < FIELD_W) ? COST_BITS : FIELD_W;
    localparam int MID_W = 2 + 4 * (CW + 1);
    localparam int RES_W = $bits(res_t);

    cfg_regs_t        cfg_reg;
    cfg_regs_t        cfg_next;
    logic             in_xfer;
    logic [MID_W-1:0] front_data;
    logic [MID_W-1:0] mid_data;
    logic             mid_empty;
    logic             mid_pop;
    logic             res_full;
    logic             res_push;
    res_t             res_in;
    logic [RES_W-1:0] res_out;
    res_t             res_head;

    assign in_xfer = push && !full;

    // configuration register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_ENTRY_ZERO: cfg_next.entry_cost_zero = cfg_data;
                REG_ENTRY_ONE:  cfg_next.entry_cost_one  = cfg_data;
                REG_EXIT_ZERO:  cfg_next.exit_cost_zero  = cfg_data;
                REG_EXIT_ONE:   cfg_next.exit_cost_one   = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front end
    tla_front #(
        .COST_BITS (COST_BITS),
        .MID_W     (MID_W)
    ) u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg                 (cfg_reg),
        .item_xfer           (in_xfer),
        .work_time_zero      (work_time_zero),
        .work_time_one       (work_time_one),
        .move_cost_from_zero (move_cost_from_zero),
        .move_cost_from_one  (move_cost_from_one),
        .last_station        (last_station),
        .mid_data            (front_data)
    );

    // station queue between front and back
    tla_fifo #(
        .WIDTH (MID_W),
        .DEPTH (2)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (front_data),
        .full    (full),
        .rd_en   (mid_pop),
        .rd_data (mid_data),
        .empty   (mid_empty)
    );

    // back end
    tla_back #(
        .COST_BITS (COST_BITS),
        .SUM_BITS  (SUM_BITS),
        .MID_W     (MID_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .mid_data  (mid_data),
        .mid_empty (mid_empty),
        .mid_pop   (mid_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_in)
    );

    // result queue
    tla_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_out),
        .empty   (empty)
    );

    assign res_head       = res_t'(res_out);
    assign best_cost_zero = res_head.best_cost_zero;
    assign best_cost_one  = res_head.best_cost_one;
    assign pred_for_zero  = res_head.pred_for_zero;
    assign pred_for_one   = res_head.pred_for_one;
    assign total_cost     = res_head.total_cost;
    assign exit_line      = res_head.exit_line;
    assign final_res      = res_head.final_res;

endmodule

`default_nettype wire
